// ===== hw/rtl/mmcn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared types and constants of the min/max color normalizer.
// ----------------------------------------------------------------------------
package mmcn_pkg;

    typedef enum logic
    {
        OP_MEASURE,
        OP_CONVERT
    } op_t;

    // head of the request queue as seen by the back end
    typedef struct packed
    {
        logic       valid;
        op_t        op;
        logic       frame_start;
    } cmd_t;

    typedef struct packed
    {
        logic       load;
        logic       step;
    } lane_ctl_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam int RES_BITS       = 8;
    localparam int DIV_STEPS      = 8;
    localparam int STEP_CNT_BITS  = 3;

    localparam logic [RES_BITS-1:0] OUT_MAX = 8'd255;

endpackage

// ===== hw/rtl/mmcn_front.sv =====
// ----------------------------------------------------------------------------
// mmcn_front
// Accepts requests, tags them as measure or convert and holds them in a
// small queue until the back end takes them.
// ----------------------------------------------------------------------------
module mmcn_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   mode,
    input  logic                   frame_start,
    input  logic [SAMPLE_BITS-1:0] red,
    input  logic [SAMPLE_BITS-1:0] green,
    input  logic [SAMPLE_BITS-1:0] blue,
    output mmcn_pkg::cmd_t         cmd,
    output logic [SAMPLE_BITS-1:0] head_red,
    output logic [SAMPLE_BITS-1:0] head_green,
    output logic [SAMPLE_BITS-1:0] head_blue,
    input  logic                   deq
);

    mmcn_pkg::op_t                          op_reg    [mmcn_pkg::QUEUE_DEPTH];
    logic                                   fs_reg    [mmcn_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]                 red_reg   [mmcn_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]                 green_reg [mmcn_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]                 blue_reg  [mmcn_pkg::QUEUE_DEPTH];

    logic [mmcn_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mmcn_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mmcn_pkg::QUEUE_CNT_BITS-1:0]    count_reg, count_next;

    logic                                   push_ok;
    logic                                   deq_ok;
    mmcn_pkg::op_t                          op_in;

    assign full    = (count_reg == mmcn_pkg::QUEUE_CNT_BITS'(mmcn_pkg::QUEUE_DEPTH));
    assign push_ok = push && !full;
    assign deq_ok  = deq && (count_reg != '0);
    assign op_in   = mode ? mmcn_pkg::OP_CONVERT : mmcn_pkg::OP_MEASURE;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq_ok  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push_ok, deq_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            op_reg[wr_ptr_reg]    <= op_in;
            fs_reg[wr_ptr_reg]    <= frame_start;
            red_reg[wr_ptr_reg]   <= red;
            green_reg[wr_ptr_reg] <= green;
            blue_reg[wr_ptr_reg]  <= blue;
        end
    end

    assign cmd.valid       = (count_reg != '0);
    assign cmd.op          = op_reg[rd_ptr_reg];
    assign cmd.frame_start = fs_reg[rd_ptr_reg];
    assign head_red        = red_reg[rd_ptr_reg];
    assign head_green      = green_reg[rd_ptr_reg];
    assign head_blue       = blue_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/mmcn_lane.sv =====
// ----------------------------------------------------------------------------
// mmcn_lane
// One channel of the convert path: offset against the low mark, range
// checks, and an 8-step restoring division giving diff*255/range.
// ----------------------------------------------------------------------------
module mmcn_lane #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            clk,
    input  mmcn_pkg::lane_ctl_t             ctl,
    input  logic [SAMPLE_BITS-1:0]          key,
    input  logic [SAMPLE_BITS-1:0]          low_mark,
    input  logic [SAMPLE_BITS-1:0]          range,
    output logic [mmcn_pkg::RES_BITS-1:0]   level
);

    logic                               zero_reg;
    logic                               sat_reg;
    logic [SAMPLE_BITS-1:0]             diff_reg;
    logic [SAMPLE_BITS-1:0]             rem_reg;
    logic [mmcn_pkg::RES_BITS-1:0]      quo_reg;

    logic [SAMPLE_BITS-1:0]             diff;
    logic [SAMPLE_BITS:0]               rem_sh;
    logic [SAMPLE_BITS:0]               rem_sub;
    logic                               take;

    assign diff    = key - low_mark;
    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, range};
    assign take    = (rem_sh >= {1'b0, range});

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            zero_reg <= (key <= low_mark);
            sat_reg  <= (diff >= range);
            diff_reg <= diff;
            rem_reg  <= diff;
            quo_reg  <= '0;
        end
        else if (ctl.step)
        begin
            rem_reg <= take ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
            quo_reg <= {quo_reg[mmcn_pkg::RES_BITS-2:0], take};
        end
    end

    // 256*d/r minus one when the remainder fell below d gives 255*d/r
    always_comb
    begin
        if (zero_reg)
            level = '0;
        else if (sat_reg)
            level = mmcn_pkg::OUT_MAX;
        else
            level = quo_reg - mmcn_pkg::RES_BITS'(rem_reg < diff_reg);
    end

endmodule

// ===== hw/rtl/mmcn_back.sv =====
// ----------------------------------------------------------------------------
// mmcn_back
// Executes queued requests: folds measure requests into the marks and runs
// convert requests through three channel lanes into the result register.
// ----------------------------------------------------------------------------
module mmcn_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmcn_pkg::cmd_t                  cmd,
    input  logic [SAMPLE_BITS-1:0]          head_red,
    input  logic [SAMPLE_BITS-1:0]          head_green,
    input  logic [SAMPLE_BITS-1:0]          head_blue,
    output logic                            deq,
    input  logic                            pop,
    output logic                            empty,
    output logic [mmcn_pkg::RES_BITS-1:0]   red_out,
    output logic [mmcn_pkg::RES_BITS-1:0]   green_out,
    output logic [mmcn_pkg::RES_BITS-1:0]   blue_out,
    output logic                            flat_range
);

    localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    mmcn_pkg::state_t                       state_reg, state_next;
    logic [mmcn_pkg::STEP_CNT_BITS-1:0]     step_cnt_reg;
    logic [SAMPLE_BITS-1:0]                 low_reg;
    logic [SAMPLE_BITS-1:0]                 high_reg;
    logic                                   flat_reg;
    logic                                   out_valid_reg;
    logic [mmcn_pkg::RES_BITS-1:0]          red_out_reg, green_out_reg, blue_out_reg;
    logic                                   flat_out_reg;

    mmcn_pkg::lane_ctl_t                    lane_ctl;
    logic                                   measure_en;
    logic                                   out_load;
    logic                                   out_free;
    logic                                   last_step;

    logic [SAMPLE_BITS-1:0]                 key_r, key_g, key_b;
    logic [SAMPLE_BITS-1:0]                 base_low, base_high;
    logic [SAMPLE_BITS-1:0]                 lo_a, lo_b, low_next;
    logic [SAMPLE_BITS-1:0]                 hi_a, hi_b, high_next;
    logic [SAMPLE_BITS-1:0]                 range_now;
    logic [mmcn_pkg::RES_BITS-1:0]          lvl_r, lvl_g, lvl_b;

    // sign flip turns signed order into unsigned order
    assign key_r = head_red   ^ SIGN_BIT;
    assign key_g = head_green ^ SIGN_BIT;
    assign key_b = head_blue  ^ SIGN_BIT;

    assign base_low  = cmd.frame_start ? '1 : low_reg;
    assign base_high = cmd.frame_start ? '0 : high_reg;

    // marks only move in idle, so this holds through a whole convert
    assign range_now = high_reg - low_reg;

    always_comb
    begin
        lo_a      = (key_r < key_g) ? key_r : key_g;
        lo_b      = (key_b < base_low) ? key_b : base_low;
        low_next  = (lo_a < lo_b) ? lo_a : lo_b;
        hi_a      = (key_r > key_g) ? key_r : key_g;
        hi_b      = (key_b > base_high) ? key_b : base_high;
        high_next = (hi_a > hi_b) ? hi_a : hi_b;
    end

    assign out_free  = !out_valid_reg || pop;
    assign last_step = (step_cnt_reg == mmcn_pkg::STEP_CNT_BITS'(mmcn_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmcn_pkg::ST_IDLE:
            begin
                if (cmd.valid && (cmd.op == mmcn_pkg::OP_CONVERT))
                    state_next = mmcn_pkg::ST_DIV;
            end
            mmcn_pkg::ST_DIV:
            begin
                if (last_step)
                    state_next = mmcn_pkg::ST_EMIT;
            end
            mmcn_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = mmcn_pkg::ST_IDLE;
            end
            default:
                state_next = mmcn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        deq           = 1'b0;
        measure_en    = 1'b0;
        lane_ctl.load = 1'b0;
        lane_ctl.step = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            mmcn_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    deq = 1'b1;
                    if (cmd.op == mmcn_pkg::OP_MEASURE)
                        measure_en = 1'b1;
                    else
                        lane_ctl.load = 1'b1;
                end
            end
            mmcn_pkg::ST_DIV:
                lane_ctl.step = 1'b1;
            mmcn_pkg::ST_EMIT:
                out_load = out_free;
            default:
                deq = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmcn_pkg::ST_IDLE;
            step_cnt_reg  <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (lane_ctl.load)
                step_cnt_reg <= '0;
            else if (lane_ctl.step)
                step_cnt_reg <= step_cnt_reg + 1'b1;
            if (measure_en)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctl.load)
        begin
            flat_reg  <= (high_reg <= low_reg);
        end
        if (out_load)
        begin
            red_out_reg   <= flat_reg ? '0 : lvl_r;
            green_out_reg <= flat_reg ? '0 : lvl_g;
            blue_out_reg  <= flat_reg ? '0 : lvl_b;
            flat_out_reg  <= flat_reg;
        end
    end

    mmcn_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_red (
        .clk      (clk),
        .ctl      (lane_ctl),
        .key      (key_r),
        .low_mark (low_reg),
        .range    (range_now),
        .level    (lvl_r)
    );

    mmcn_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_green (
        .clk      (clk),
        .ctl      (lane_ctl),
        .key      (key_g),
        .low_mark (low_reg),
        .range    (range_now),
        .level    (lvl_g)
    );

    mmcn_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_blue (
        .clk      (clk),
        .ctl      (lane_ctl),
        .key      (key_b),
        .low_mark (low_reg),
        .range    (range_now),
        .level    (lvl_b)
    );

    assign empty      = !out_valid_reg;
    assign red_out    = red_out_reg;
    assign green_out  = green_out_reg;
    assign blue_out   = blue_out_reg;
    assign flat_range = flat_out_reg;

endmodule

// ===== hw/rtl/minmax_color_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// minmax_color_normalizer_top
// Min/max normalization of signed fixed-point RGB pixels to 8 bits.
// ----------------------------------------------------------------------------
// Requests enter a 4-entry queue and are executed in order by the back end.
// A measure request is folded into the marks in idle and yields no result. A
// convert request is loaded, run through eight restoring-division steps on
// three channel lanes side by side, and then written into the result register;
// a full result register holds the back end in the emit state until popped.
// The queue keeps taking requests meanwhile, so push sees full only when all
// four queue entries hold waiting requests.
module minmax_color_normalizer_top #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            mode,
    input  logic                            frame_start,
    input  logic signed [SAMPLE_BITS-1:0]   red,
    input  logic signed [SAMPLE_BITS-1:0]   green,
    input  logic signed [SAMPLE_BITS-1:0]   blue,
    input  logic                            pop,
    output logic                            empty,
    output logic [mmcn_pkg::RES_BITS-1:0]   red_out,
    output logic [mmcn_pkg::RES_BITS-1:0]   green_out,
    output logic [mmcn_pkg::RES_BITS-1:0]   blue_out,
    output logic                            flat_range
);

    mmcn_pkg::cmd_t             cmd;
    logic [SAMPLE_BITS-1:0]     head_red, head_green, head_blue;
    logic                       deq;

    mmcn_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .frame_start (frame_start),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cmd         (cmd),
        .head_red    (head_red),
        .head_green  (head_green),
        .head_blue   (head_blue),
        .deq         (deq)
    );

    mmcn_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .head_red    (head_red),
        .head_green  (head_green),
        .head_blue   (head_blue),
        .deq         (deq),
        .pop         (pop),
        .empty       (empty),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .flat_range  (flat_range)
    );

endmodule

// ===== hw/rtl/mmcn_checker.sv =====
// ----------------------------------------------------------------------------
// mmcn_checker
// Port-level checks of the min/max color normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mmcn_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             full,
    input logic                             pop,
    input logic                             empty,
    input logic [mmcn_pkg::RES_BITS-1:0]    red_out,
    input logic [mmcn_pkg::RES_BITS-1:0]    green_out,
    input logic [mmcn_pkg::RES_BITS-1:0]    blue_out,
    input logic                             flat_range
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not clear during reset");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && flat_range) |-> (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("flat range result with nonzero channels");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(red_out) && $stable(green_out)
                              && $stable(blue_out) && $stable(flat_range)))
        else $error("stalled result changed");

endmodule

bind minmax_color_normalizer_top mmcn_checker u_mmcn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .flat_range (flat_range)
);
